@@ rtl/core/vri_pkg.sv @@
// ----------------------------------------------------------------------------
// vri_pkg
// Types, codes and constants shared by the video register interface.
// ----------------------------------------------------------------------------
package vri_pkg;

  localparam int VRI_OBJECT_BYTES = 256;
  localparam int VRI_OBJ_PTR_W    = 8;

  // access opcodes
  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_VBL_START = 2'd2,
    OP_VBL_END   = 2'd3
  } vri_op_t;

  // register indexes
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // chip variants
  localparam logic [2:0] VAR_EARLY = 3'd1;
  localparam logic [2:0] VAR_ARC1  = 3'd3;
  localparam logic [2:0] VAR_ARC2  = 3'd4;
  localparam logic [2:0] VAR_ARC3  = 3'd5;
  localparam logic [2:0] VAR_ARC4  = 3'd6;

  // fixed status low bits on arcade parts
  localparam logic [7:0] STAT_LOW_A = 8'h1b;
  localparam logic [7:0] STAT_LOW_B = 8'h3d;
  localparam logic [7:0] STAT_LOW_C = 8'h1c;

  // bus write codes
  localparam logic [1:0] BUS_NONE = 2'd0;
  localparam logic [1:0] BUS_MEM  = 2'd1;
  localparam logic [1:0] BUS_PAL  = 2'd2;

  localparam logic [13:0] PAL_BASE = 14'h3f00;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic       rendering_busy;
    logic       sprite_zero_hit;
    logic       sprite_overflow;
    logic [7:0] memory_data;
    logic [5:0] palette_data;
  } vri_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_line;
    logic [13:0] bus_address;
    logic [1:0]  bus_write;
    logic        bus_read_taken;
    logic [3:0]  control_flags;
    logic [7:0]  mask_bits;
    logic [14:0] temp_address;
    logic [14:0] vram_address;
    logic [2:0]  fine_x;
    logic [7:0]  object_address;
  } vri_result_t;

  typedef struct packed {
    logic                     en;
    logic [VRI_OBJ_PTR_W-1:0] addr;
    logic [7:0]               data;
  } vri_obj_wr_t;

endpackage

@@ rtl/core/vri_if.sv @@
// ----------------------------------------------------------------------------
// vri_if
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
interface vri_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic       rendering_busy;
  logic       sprite_zero_hit;
  logic       sprite_overflow;
  logic [7:0] memory_data;
  logic [5:0] palette_data;

  modport source (output valid, opcode, reg_index, write_data, rendering_busy,
                  sprite_zero_hit, sprite_overflow, memory_data, palette_data,
                  input ready);
  modport sink (input valid, opcode, reg_index, write_data, rendering_busy,
                sprite_zero_hit, sprite_overflow, memory_data, palette_data,
                output ready);
endinterface

interface vri_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        nmi_line;
  logic [13:0] bus_address;
  logic [1:0]  bus_write;
  logic        bus_read_taken;
  logic [3:0]  control_flags;
  logic [7:0]  mask_bits;
  logic [14:0] temp_address;
  logic [14:0] vram_address;
  logic [2:0]  fine_x;
  logic [7:0]  object_address;

  modport source (output valid, read_data, nmi_line, bus_address, bus_write,
                  bus_read_taken, control_flags, mask_bits, temp_address,
                  vram_address, fine_x, object_address, input ready);
  modport sink (input valid, read_data, nmi_line, bus_address, bus_write,
                bus_read_taken, control_flags, mask_bits, temp_address,
                vram_address, fine_x, object_address, output ready);
endinterface

interface vri_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] chip_variant;

  modport source (output valid, chip_variant, input ready);
  modport sink (input valid, chip_variant, output ready);
endinterface

@@ rtl/core/vri_obj_mem.sv @@
// ----------------------------------------------------------------------------
// vri_obj_mem
// Object memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vri_obj_mem import vri_pkg::*; #(
  parameter int OBJECT_BYTES = VRI_OBJECT_BYTES,
  parameter int ADDR_W       = $clog2(OBJECT_BYTES)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data_r
);

  logic [7:0] mem [OBJECT_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ rtl/core/vri_core.sv @@
// ----------------------------------------------------------------------------
// vri_core
// Register state and the combinational update for one bus item.
// ----------------------------------------------------------------------------
module vri_core import vri_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  vri_item_t                item,
  input  logic [2:0]               chip_variant,
  input  logic [7:0]               obj_rdata,
  output logic [VRI_OBJ_PTR_W-1:0] obj_raddr,
  output vri_obj_wr_t              obj_wr,
  output vri_result_t              res
);

  logic [7:0]               latch_r, latch_nxt;
  logic [7:0]               rbuf_r, rbuf_nxt;
  logic [14:0]              cur_r, cur_nxt;
  logic [14:0]              tmp_r, tmp_nxt;
  logic [2:0]               fine_r, fine_nxt;
  logic                     second_r, second_nxt;
  logic [7:0]               ctrl_r, ctrl_nxt;
  logic [7:0]               mask_r, mask_nxt;
  logic                     vbl_r, vbl_nxt;
  logic                     nmi_hold_r, nmi_hold_nxt;
  logic [VRI_OBJ_PTR_W-1:0] ptr_r, ptr_nxt;

  logic [7:0]  rd;
  logic [1:0]  bwrite;
  logic        taken;
  logic        access;
  logic [13:0] acc_addr;
  logic [14:0] step;
  logic [2:0]  reg_sel;

  always_comb begin
    latch_nxt    = latch_r;
    rbuf_nxt     = rbuf_r;
    cur_nxt      = cur_r;
    tmp_nxt      = tmp_r;
    fine_nxt     = fine_r;
    second_nxt   = second_r;
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    vbl_nxt      = vbl_r;
    nmi_hold_nxt = nmi_hold_r;
    ptr_nxt      = ptr_r;
    rd           = 8'd0;
    bwrite       = BUS_NONE;
    taken        = 1'b0;
    access       = 1'b0;
    acc_addr     = cur_r[13:0];
    step         = ctrl_r[2] ? 15'd32 : 15'd1;
    reg_sel      = item.reg_index;
    obj_wr       = '0;

    if (go) begin
      case (item.opcode)
        OP_READ: begin
          case (item.reg_index)
            REG_STATUS: begin
              rd[7:6] = {vbl_r, item.sprite_zero_hit};
              case (chip_variant)
                VAR_ARC1, VAR_ARC4: rd = rd | STAT_LOW_A;
                VAR_ARC2: rd = rd | STAT_LOW_B;
                VAR_ARC3: rd = rd | STAT_LOW_C;
                default: rd[5:0] = {item.sprite_overflow, latch_r[4:0]};
              endcase
              second_nxt   = 1'b0;
              nmi_hold_nxt = 1'b0;
              vbl_nxt      = 1'b0;
            end
            REG_OAM_DATA: begin
              if (chip_variant != VAR_EARLY) begin
                latch_nxt = obj_rdata;
              end
              rd = latch_nxt;
            end
            REG_DATA: begin
              if (!item.rendering_busy) begin
                access = 1'b1;
                // palette reads bypass the buffer but keep the top latch bits
                if (acc_addr < PAL_BASE) begin
                  latch_nxt = rbuf_r;
                end else begin
                  latch_nxt = {latch_r[7:6], item.palette_data};
                end
                rbuf_nxt = item.memory_data;
                taken    = 1'b1;
                cur_nxt  = cur_r + step;
                rd       = latch_nxt;
              end
            end
            default: rd = latch_r;
          endcase
        end
        OP_WRITE: begin
          latch_nxt = item.write_data;
          // arcade parts swap control and mask
          if (chip_variant >= VAR_ARC1 && reg_sel[2:1] == 2'b00) begin
            reg_sel[0] = ~reg_sel[0];
          end
          case (reg_sel)
            REG_CTRL: begin
              ctrl_nxt        = item.write_data;
              tmp_nxt[11:10]  = item.write_data[1:0];
            end
            REG_MASK: mask_nxt = item.write_data;
            REG_OAM_ADDR: ptr_nxt = item.write_data;
            REG_OAM_DATA: begin
              obj_wr.en   = 1'b1;
              obj_wr.addr = ptr_r;
              obj_wr.data = item.write_data;
              ptr_nxt     = ptr_r + 1'b1;
            end
            REG_SCROLL: begin
              if (!second_r) begin
                fine_nxt     = item.write_data[2:0];
                tmp_nxt[4:0] = item.write_data[7:3];
              end else begin
                tmp_nxt[14:12] = item.write_data[2:0];
                tmp_nxt[9:5]   = item.write_data[7:3];
              end
              second_nxt = ~second_r;
            end
            REG_ADDR: begin
              if (!second_r) begin
                tmp_nxt[14]   = 1'b0;
                tmp_nxt[13:8] = item.write_data[5:0];
              end else begin
                tmp_nxt[7:0] = item.write_data;
                cur_nxt      = tmp_nxt;
              end
              second_nxt = ~second_r;
            end
            REG_DATA: begin
              if (!item.rendering_busy) begin
                access  = 1'b1;
                bwrite  = (acc_addr < PAL_BASE) ? BUS_MEM : BUS_PAL;
                cur_nxt = cur_r + step;
              end
            end
            default: ;
          endcase
        end
        OP_VBL_START: begin
          vbl_nxt      = 1'b1;
          nmi_hold_nxt = 1'b1;
        end
        default: begin
          vbl_nxt      = 1'b0;
          nmi_hold_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r    <= '0;
      rbuf_r     <= '0;
      cur_r      <= '0;
      tmp_r      <= '0;
      fine_r     <= '0;
      second_r   <= 1'b0;
      ctrl_r     <= '0;
      mask_r     <= '0;
      vbl_r      <= 1'b0;
      nmi_hold_r <= 1'b0;
      ptr_r      <= '0;
    end else begin
      latch_r    <= latch_nxt;
      rbuf_r     <= rbuf_nxt;
      cur_r      <= cur_nxt;
      tmp_r      <= tmp_nxt;
      fine_r     <= fine_nxt;
      second_r   <= second_nxt;
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      vbl_r      <= vbl_nxt;
      nmi_hold_r <= nmi_hold_nxt;
      ptr_r      <= ptr_nxt;
    end
  end

  // read ahead at the pointer the next item will see
  assign obj_raddr = ptr_nxt;

  always_comb begin
    res.read_data      = rd;
    res.nmi_line       = ctrl_nxt[7] & nmi_hold_nxt & vbl_nxt;
    res.bus_address    = access ? acc_addr : cur_nxt[13:0];
    res.bus_write      = bwrite;
    res.bus_read_taken = taken;
    res.control_flags  = ctrl_nxt[6:3];
    res.mask_bits      = mask_nxt;
    res.temp_address   = tmp_nxt;
    res.vram_address   = cur_nxt;
    res.fine_x         = fine_nxt;
    res.object_address = ptr_nxt;
  end

endmodule

@@ rtl/core/video_register_interface.sv @@
// An accepted item passes the input register, the core update and the result register.
// Throughput: one item per cycle while out_chan.ready does not stall the result register.
// The object-memory read port is fed from the next pointer value, ready for the next item.
// Reset (rst_n low, synchronous): valid flags, variant and core state clear to zero;
// payload registers and object memory are not cleared; they hold unknown data until written.
// ----------------------------------------------------------------------------
// video_register_interface
// CPU register file of a tile video processor with scroll/address latches.
// ----------------------------------------------------------------------------
module video_register_interface import vri_pkg::*; #(
  parameter int OBJECT_BYTES = VRI_OBJECT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  vri_in_if.sink      in_chan,
  vri_out_if.source   out_chan,
  vri_cfg_if.sink     cfg_chan
);

  localparam int ADDR_W = $clog2(OBJECT_BYTES);

  logic                     in_vld_r;
  vri_item_t                in_item_r;
  logic                     out_vld_r;
  vri_result_t              out_res_r;
  logic [2:0]               variant_r;
  logic                     advance;
  vri_result_t              res;
  vri_obj_wr_t              obj_wr;
  logic [VRI_OBJ_PTR_W-1:0] obj_raddr;
  logic [7:0]               obj_rdata;

  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      variant_r <= '0;
    end else begin
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_chan.valid) begin
        variant_r <= cfg_chan.chip_variant;
      end
    end
  end

  // payload registers: load on acceptance / advance
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r <= '{opcode:          in_chan.opcode,
                     reg_index:       in_chan.reg_index,
                     write_data:      in_chan.write_data,
                     rendering_busy:  in_chan.rendering_busy,
                     sprite_zero_hit: in_chan.sprite_zero_hit,
                     sprite_overflow: in_chan.sprite_overflow,
                     memory_data:     in_chan.memory_data,
                     palette_data:    in_chan.palette_data};
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  vri_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (advance),
    .item         (in_item_r),
    .chip_variant (variant_r),
    .obj_rdata    (obj_rdata),
    .obj_raddr    (obj_raddr),
    .obj_wr       (obj_wr),
    .res          (res)
  );

  vri_obj_mem #(
    .OBJECT_BYTES (OBJECT_BYTES),
    .ADDR_W       (ADDR_W)
  ) u_obj_mem (
    .clk       (clk),
    .wr_en     (obj_wr.en),
    .wr_addr   (obj_wr.addr[ADDR_W-1:0]),
    .wr_data   (obj_wr.data),
    .rd_addr   (obj_raddr[ADDR_W-1:0]),
    .rd_data_r (obj_rdata)
  );

  assign out_chan.valid          = out_vld_r;
  assign out_chan.read_data      = out_res_r.read_data;
  assign out_chan.nmi_line       = out_res_r.nmi_line;
  assign out_chan.bus_address    = out_res_r.bus_address;
  assign out_chan.bus_write      = out_res_r.bus_write;
  assign out_chan.bus_read_taken = out_res_r.bus_read_taken;
  assign out_chan.control_flags  = out_res_r.control_flags;
  assign out_chan.mask_bits      = out_res_r.mask_bits;
  assign out_chan.temp_address   = out_res_r.temp_address;
  assign out_chan.vram_address   = out_res_r.vram_address;
  assign out_chan.fine_x         = out_res_r.fine_x;
  assign out_chan.object_address = out_res_r.object_address;

endmodule
